// ----- src/rarm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rarm_pkg: shared types and constants
// Opcodes, field widths and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rarm_pkg;
	localparam int NUM_BITS_DEF = 16;
	localparam int DEN_BITS_DEF = 16;
	localparam int OPC_BITS     = 2;
	localparam int IN_NUM_W     = 16;
	localparam int IN_DEN_W     = 16;
	localparam int OUT_NUM_W    = 33;
	localparam int OUT_DEN_W    = 32;

	localparam logic [OPC_BITS-1:0] OP_ADD = 2'd0;
	localparam logic [OPC_BITS-1:0] OP_MUL = 2'd1;
	localparam logic [OPC_BITS-1:0] OP_INC = 2'd2;

	typedef struct packed {
		logic load;     // capture request and form raw fraction
		logic gcd_init; // start gcd
		logic gcd_step; // one step of the gcd remainder loop
		logic div_init; // start the two divisions
		logic div_step;
		logic finish;   // latch result register
	} rarm_cmd_t;

	typedef struct packed {
		logic trivial;  // error or zero numerator
		logic gcd_done;
		logic div_done;
	} rarm_sts_t;
endpackage
`default_nettype wire

// ----- src/rarm_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rarm_stream_if: valid/ready channel
// Carries one request or one result with its payload.
// ----------------------------------------------------------------------------
interface rarm_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/rarm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rarm_datapath: fraction arithmetic, gcd and division units
// Forms the raw fraction, runs a Euclid gcd by restoring remainders, then
// divides numerator and denominator by the gcd bit-serially.
// ----------------------------------------------------------------------------
module rarm_datapath #(
	parameter int NUM_BITS = 16,
	parameter int DEN_BITS = 16
) (
	input  wire                                   clk,
	input  wire rarm_pkg::rarm_cmd_t              cmd,
	output rarm_pkg::rarm_sts_t                   sts,
	input  wire [rarm_pkg::OPC_BITS-1:0]          opcode,
	input  wire [rarm_pkg::IN_NUM_W-1:0]          a_numerator,
	input  wire [rarm_pkg::IN_DEN_W-1:0]          a_denominator,
	input  wire [rarm_pkg::IN_NUM_W-1:0]          b_numerator,
	input  wire [rarm_pkg::IN_DEN_W-1:0]          b_denominator,
	output logic [rarm_pkg::OUT_NUM_W-1:0]        result_numerator,
	output logic [rarm_pkg::OUT_DEN_W-1:0]        result_denominator,
	output logic                                  divide_error
);
	import rarm_pkg::*;
	localparam int NW = (NUM_BITS > DEN_BITS) ? NUM_BITS : DEN_BITS;
	localparam int PW = 2 * NW;
	localparam int MW = PW + 1;
	localparam int CW = $clog2(MW + 1);

	logic [NUM_BITS-1:0] an, bn, ma, mb;
	logic [DEN_BITS-1:0] ad, bd;
	logic                sa, sb;
	assign an = NUM_BITS'(a_numerator);
	assign bn = NUM_BITS'(b_numerator);
	assign ad = DEN_BITS'(a_denominator);
	assign bd = DEN_BITS'(b_denominator);
	assign sa = an[NUM_BITS-1];
	assign sb = bn[NUM_BITS-1];
	assign ma = sa ? (~an + 1'b1) : an;
	assign mb = sb ? (~bn + 1'b1) : bn;

	// raw fraction: products registered first, then the sum
	logic [PW-1:0]       p1_q, p2_q;
	logic [2*DEN_BITS-1:0] den_prod_q;
	logic                s1_q, s2_q, add_q, err_q, stage_q;
	logic [MW-1:0]       num_q, den_q;
	logic                sn_q;
	// gcd and division state
	logic [MW-1:0]       x_q, y_q, r_q, g_q, qn_q, qd_q, rn_q, rd_q;
	logic [CW-1:0]       cnt_q;
	logic                in_mod_q;

	logic [MW-1:0] p1x, p2x, rem_try, rn_sh, rd_sh;
	assign p1x = MW'(p1_q);
	assign p2x = MW'(p2_q);

	assign sts.trivial  = err_q || (num_q == '0);
	assign sts.gcd_done = (y_q == '0) && !in_mod_q;
	assign sts.div_done = (cnt_q == '0);

	assign rem_try = {r_q[MW-2:0], x_q[MW-1]};
	assign rn_sh   = {rn_q[MW-2:0], qn_q[MW-1]};
	assign rd_sh   = {rd_q[MW-2:0], qd_q[MW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q   <= (opcode == OP_INC) ? (ad == '0) :
				((opcode == OP_ADD || opcode == OP_MUL) && (ad == '0 || bd == '0));
			add_q   <= (opcode != OP_MUL);
			stage_q <= 1'b1;
			case (opcode)
				OP_ADD: begin
					p1_q <= PW'(ma) * PW'(bd); s1_q <= sa;
					p2_q <= PW'(mb) * PW'(ad); s2_q <= sb;
					den_prod_q <= ad * bd;
				end
				OP_MUL: begin
					p1_q <= PW'(ma) * PW'(mb); s1_q <= sa ^ sb;
					p2_q <= '0; s2_q <= 1'b0;
					den_prod_q <= ad * bd;
				end
				OP_INC: begin
					p1_q <= PW'(ma); s1_q <= sa;
					p2_q <= PW'(ad); s2_q <= 1'b0;
					den_prod_q <= (2*DEN_BITS)'(ad);
				end
				default: begin
					p1_q <= '0; s1_q <= 1'b0;
					p2_q <= '0; s2_q <= 1'b0;
					den_prod_q <= '0;
				end
			endcase
			num_q <= '1; // nonzero until formed
		end else if (stage_q) begin
			stage_q <= 1'b0;
			den_q   <= MW'(den_prod_q);
			if (s1_q == s2_q || !add_q) begin
				num_q <= p1x + p2x; sn_q <= s1_q;
			end else if (p1x >= p2x) begin
				num_q <= p1x - p2x; sn_q <= s1_q;
			end else begin
				num_q <= p2x - p1x; sn_q <= s2_q;
			end
		end

		// gcd: x mod y by restoring division, MW steps per remainder
		if (cmd.gcd_init) begin
			x_q <= num_q; y_q <= den_q; in_mod_q <= 1'b0;
		end else if (cmd.gcd_step) begin
			if (!in_mod_q) begin
				g_q <= x_q; r_q <= '0; cnt_q <= CW'(MW); in_mod_q <= 1'b1;
			end else if (cnt_q != '0) begin
				x_q   <= {x_q[MW-2:0], 1'b0};
				r_q   <= (rem_try >= y_q) ? rem_try - y_q : rem_try;
				cnt_q <= cnt_q - 1'b1;
			end else begin
				x_q <= y_q; y_q <= r_q; in_mod_q <= 1'b0;
			end
		end

		// two parallel quotient divisions by the gcd
		if (cmd.div_init) begin
			g_q <= x_q; qn_q <= num_q; qd_q <= den_q;
			rn_q <= '0; rd_q <= '0; cnt_q <= CW'(MW);
		end else if (cmd.div_step && cnt_q != '0) begin
			qn_q  <= {qn_q[MW-2:0], rn_sh >= g_q};
			rn_q  <= (rn_sh >= g_q) ? rn_sh - g_q : rn_sh;
			qd_q  <= {qd_q[MW-2:0], rd_sh >= g_q};
			rd_q  <= (rd_sh >= g_q) ? rd_sh - g_q : rd_sh;
			cnt_q <= cnt_q - 1'b1;
		end

		if (cmd.finish) begin
			divide_error <= err_q;
			if (sts.trivial) begin
				result_numerator   <= '0;
				result_denominator <= 32'd1;
			end else begin
				result_numerator   <= sn_q ? 33'(~qn_q + 1'b1) : 33'(qn_q);
				result_denominator <= 32'(qd_q);
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/rarm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rarm_ctrl: sequencing state machine
// Takes a request, steps the gcd and division units, presents the result.
// ----------------------------------------------------------------------------
module rarm_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	output rarm_pkg::rarm_cmd_t      cmd,
	input  wire rarm_pkg::rarm_sts_t sts
);
	import rarm_pkg::*;
	typedef enum logic [2:0] {S_IDLE, S_FORM, S_CHECK, S_GCD, S_DIV, S_FIN} state_t;
	state_t state_q;
	logic   out_valid_q;

	// the result register may still hold an untaken result while the next runs
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:  cmd.load     = in_valid;
			S_CHECK: cmd.gcd_init = 1'b1;
			S_GCD:   begin
				cmd.gcd_step = !sts.gcd_done;
				cmd.div_init = sts.gcd_done;
			end
			S_DIV:   cmd.div_step = 1'b1;
			S_FIN:   cmd.finish   = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_FORM;
				S_FORM:  state_q <= S_CHECK;
				S_CHECK: state_q <= sts.trivial ? S_FIN : S_GCD;
				S_GCD:   if (sts.gcd_done) state_q <= S_DIV;
				S_DIV:   if (sts.div_done) state_q <= S_FIN;
				S_FIN:   if (cmd.finish) begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/rational_add_multiply_reduce_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce_core: fraction add/multiply/increment, reduced
// in_ch carries {opcode, a_numerator, a_denominator, b_numerator,
// b_denominator}; out_ch carries {result_numerator, result_denominator,
// divide_error}. One request is worked at a time. An error or zero result
// goes straight to the result register; otherwise k Euclid remainder steps
// run, each of MW shift-subtract steps, MW = 2*max(NUM_BITS, DEN_BITS)+1
// (33 at defaults), then both bit-serial divisions by the gcd. The next
// request can be accepted in the cycle after the previous result is loaded.
// A new request is taken once the previous result is in the output
// register, even if the receiver has not yet taken it; if the receiver
// stalls, the next result waits in the controller until the register frees.
// Reset clears the controller and the output valid; no result is pending
// after reset. Input bits above NUM_BITS/DEN_BITS are ignored; results wrap
// to the output widths at larger parameters.
// ----------------------------------------------------------------------------
module rational_add_multiply_reduce_core #(
	parameter int NUM_BITS = rarm_pkg::NUM_BITS_DEF,
	parameter int DEN_BITS = rarm_pkg::DEN_BITS_DEF
) (
	input wire          clk,
	input wire          arst_n,
	rarm_stream_if.sink   in_ch,
	rarm_stream_if.source out_ch
);
	import rarm_pkg::*;
	rarm_cmd_t cmd;
	rarm_sts_t sts;
	logic [32:0] rn;
	logic [31:0] rd;
	logic        de;

	rarm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .sts
	);

	rarm_datapath #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_dp (
		.clk, .cmd, .sts,
		.opcode(in_ch.data[65:64]),
		.a_numerator(in_ch.data[63:48]),
		.a_denominator(in_ch.data[47:32]),
		.b_numerator(in_ch.data[31:16]),
		.b_denominator(in_ch.data[15:0]),
		.result_numerator(rn), .result_denominator(rd), .divide_error(de)
	);

	assign out_ch.data = {rn, rd, de};
endmodule
`default_nettype wire

// ----- bench/rational_add_multiply_reduce_checker.sv -----
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce_checker: result predictor and comparator
// Watches both channels, computes the reduced fraction for every accepted
// request and compares it with the results in order.
// ----------------------------------------------------------------------------
module rational_add_multiply_reduce_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_fire,
	input  wire [65:0] req_data,
	input  wire        res_fire,
	input  wire [65:0] res_data,
	output int         fail_count,
	output int         pending,
	output int         result_count
);
	import rarm_pkg::*;

	logic [65:0] fraction_q[$];

	function automatic logic [65:0] reduce_fraction(input logic [65:0] req);
		logic [1:0] op;
		logic signed [63:0] an, bn, ad, bd, num, den, x, y, r;
		logic err;
		op = req[65:64];
		an = $signed(req[63:48]);
		ad = req[47:32];
		bn = $signed(req[31:16]);
		bd = req[15:0];
		err = 1'b0;
		num = 0;
		den = 1;
		case (op)
			OP_ADD: begin
				if (ad == 0 || bd == 0) err = 1'b1;
				else begin
					num = an * bd + bn * ad;
					den = ad * bd;
				end
			end
			OP_MUL: begin
				if (ad == 0 || bd == 0) err = 1'b1;
				else begin
					num = an * bn;
					den = ad * bd;
				end
			end
			OP_INC: begin
				if (ad == 0) err = 1'b1;
				else begin
					num = an + ad;
					den = ad;
				end
			end
			default: ;
		endcase
		if (err || num == 0) begin
			num = 0;
			den = 1;
		end else begin
			x = (num < 0) ? -num : num;
			y = den;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			num = num / x;
			den = den / x;
		end
		return {num[32:0], den[31:0], err};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
			fraction_q.delete();
		end else begin
			if (req_fire) fraction_q.push_back(reduce_fraction(req_data));
			if (res_fire) begin
				result_count <= result_count + 1;
				if (fraction_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", res_data);
					fail_count <= fail_count + 1;
				end else begin
					if (fraction_q[0] !== res_data) begin
						if (fail_count < 10)
							$display("mismatch: exp num %0d den %0d err %b, got num %0d den %0d err %b",
								$signed(fraction_q[0][65:33]), fraction_q[0][32:1], fraction_q[0][0],
								$signed(res_data[65:33]), res_data[32:1], res_data[0]);
						fail_count <= fail_count + 1;
					end
					void'(fraction_q.pop_front());
				end
			end
		end
	end

	assign pending = fraction_q.size();
endmodule

// ----- bench/rational_add_multiply_reduce_core_test.sv -----
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce_core_test: stimulus and verdict
// Drives directed and random fraction requests with bursty input and a
// stalling receiver, including one long hold-off, and reports the outcome.
// ----------------------------------------------------------------------------
module rational_add_multiply_reduce_core_test;
	import rarm_pkg::*;

	localparam int LIMIT = 20000;
	localparam int N_RANDOM = 1100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending, result_count, idle_cycles, sent;
	logic hold_off = 1'b0;
	logic stim_done = 1'b0;

	rarm_stream_if #(66) in_ch ();
	rarm_stream_if #(66) out_ch ();

	rational_add_multiply_reduce_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	rational_add_multiply_reduce_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_fire(in_ch.valid && in_ch.ready), .req_data(in_ch.data),
		.res_fire(out_ch.valid && out_ch.ready), .res_data(out_ch.data),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] pick_num();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_den();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'd1;
			3: return 16'($urandom_range(1, 30));
			default: return 16'($urandom);
		endcase
	endfunction

	// one request, held until accepted
	task automatic send_fraction(input logic [1:0] op, input logic [15:0] an,
		input logic [15:0] ad, input logic [15:0] bn, input logic [15:0] bd);
		in_ch.valid <= 1'b1;
		in_ch.data <= {op, an, ad, bn, bd};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drop_valid();
		in_ch.valid <= 1'b0;
	endtask

	// receiver: random stall pattern, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else if (hold_off) out_ch.ready <= 1'b0;
		else if (stim_done) out_ch.ready <= 1'b1;
		else out_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (2000) @(posedge clk);
		hold_off <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int burst;
		sent = 0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_fraction(OP_ADD, 16'h7fff, 16'hffff, 16'h7fff, 16'hfffe);
		send_fraction(OP_ADD, 16'h8000, 16'hffff, 16'h8000, 16'hffff);
		send_fraction(OP_ADD, 16'd1, 16'd2, -16'sd1, 16'd2);
		send_fraction(OP_ADD, 16'd3, 16'd0, 16'd1, 16'd5);
		send_fraction(OP_ADD, 16'd3, 16'd4, 16'd1, 16'd0);
		send_fraction(OP_ADD, -16'sd6, 16'd4, 16'd2, 16'd6);
		send_fraction(OP_MUL, 16'h8000, 16'hffff, 16'h8000, 16'd1);
		send_fraction(OP_MUL, 16'h7fff, 16'd1, 16'h8000, 16'd1);
		send_fraction(OP_MUL, 16'd0, 16'd7, 16'd5, 16'd3);
		send_fraction(OP_MUL, 16'd4, 16'd0, 16'd5, 16'd0);
		send_fraction(OP_MUL, -16'sd4, 16'd6, 16'd9, 16'd2);
		send_fraction(OP_INC, 16'h8000, 16'hffff, 16'hffff, 16'h0);
		send_fraction(OP_INC, 16'h7fff, 16'hffff, 16'h1234, 16'h0);
		send_fraction(OP_INC, -16'sd5, 16'd5, 16'd0, 16'd0);
		send_fraction(OP_INC, 16'd4, 16'd0, 16'd1, 16'd1);
		send_fraction(OP_INC, -16'sd9, 16'd6, 16'd1, 16'd1);
		send_fraction(2'd3, 16'd5, 16'd7, 16'd3, 16'd2);
		send_fraction(2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		drop_valid();
		while (sent < 18 + N_RANDOM) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				send_fraction(2'($urandom_range(0, 3)), pick_num(), pick_den(),
					pick_num(), pick_den());
				if ($urandom_range(0, 5) == 0) begin
					drop_valid();
					@(posedge clk);
				end
			end
			drop_valid();
			repeat ($urandom_range(0, 400)) @(posedge clk);
		end
		drop_valid();
		stim_done <= 1'b1;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d fraction requests (add, multiply, increment, unused opcode, zero",
			sent);
		$display("denominators, extremes); checked %0d reduced results.", result_count);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
